### hw/rtl/r2y420_pkg.sv
// ----------------------------------------------------------------------------
// r2y420_pkg: shared definitions of the RGB to YUV 4:2:0 converter
// Line store sizing, register indexes, BT.601 coefficients and the converted
// pixel type passed between the color math and the top level.
// ----------------------------------------------------------------------------
package r2y420_pkg;

  // line store sizing
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // register widths and reset values
  localparam int FW_W = 12;
  localparam int FH_W = 16;
  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 16'd480;

  // luma coefficients
  localparam int Y_R   = 66;
  localparam int Y_G   = 129;
  localparam int Y_B   = 25;
  localparam int Y_OFS = 16;

  // chroma coefficients (magnitudes, signs fixed in the math)
  localparam int CB_R = 38;
  localparam int CB_G = 74;
  localparam int CB_B = 112;
  localparam int CR_R = 112;
  localparam int CR_G = 94;
  localparam int CR_B = 18;
  localparam int C_OFS = 128;

  // rounding term and positive bias that keeps chroma sums unsigned
  localparam int ROUND      = 128;
  localparam int BIAS       = 65536;
  localparam int BIAS_SHIFT = 256;

  // one converted pixel
  typedef struct packed {
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] luma;
  } ycc_t;

endpackage

### hw/rtl/r2y420_csc.sv
// ----------------------------------------------------------------------------
// r2y420_csc: per-pixel BT.601 color space conversion
// Constant multiplies for Y, Cb and Cr, rounding shift by 8, offset and clamp
// to 0..255.
// ----------------------------------------------------------------------------
module r2y420_csc (
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  output r2y420_pkg::ycc_t       ycc
);

  logic [15:0] y_sum;
  logic [8:0]  y_raw;
  logic [16:0] cb_bias;
  logic [16:0] cr_bias;
  logic [9:0]  cb_raw;
  logic [9:0]  cr_raw;

  // luma: all terms positive, result never goes below the offset
  assign y_sum = 16'(red)   * 16'(r2y420_pkg::Y_R)
               + 16'(green) * 16'(r2y420_pkg::Y_G)
               + 16'(blue)  * 16'(r2y420_pkg::Y_B)
               + 16'(r2y420_pkg::ROUND);
  assign y_raw = {1'b0, y_sum[15:8]} + 9'(r2y420_pkg::Y_OFS);

  // chroma: biased by 65536 so the sum stays positive in 17 bits
  assign cb_bias = 17'(r2y420_pkg::BIAS + r2y420_pkg::ROUND)
                 + 17'(blue)  * 17'(r2y420_pkg::CB_B)
                 - 17'(red)   * 17'(r2y420_pkg::CB_R)
                 - 17'(green) * 17'(r2y420_pkg::CB_G);
  assign cr_bias = 17'(r2y420_pkg::BIAS + r2y420_pkg::ROUND)
                 + 17'(red)   * 17'(r2y420_pkg::CR_R)
                 - 17'(green) * 17'(r2y420_pkg::CR_G)
                 - 17'(blue)  * 17'(r2y420_pkg::CR_B);

  // remove the shifted bias and add the chroma offset
  assign cb_raw = {1'b0, cb_bias[16:8]}
                - 10'(r2y420_pkg::BIAS_SHIFT - r2y420_pkg::C_OFS);
  assign cr_raw = {1'b0, cr_bias[16:8]}
                - 10'(r2y420_pkg::BIAS_SHIFT - r2y420_pkg::C_OFS);

  // clamp to a byte
  always_comb begin
    ycc.luma = y_raw[8] ? 8'hFF : y_raw[7:0];
    if (cb_raw[9]) begin
      ycc.cb = 8'h00;
    end else if (cb_raw[8]) begin
      ycc.cb = 8'hFF;
    end else begin
      ycc.cb = cb_raw[7:0];
    end
    if (cr_raw[9]) begin
      ycc.cr = 8'h00;
    end else if (cr_raw[8]) begin
      ycc.cr = 8'hFF;
    end else begin
      ycc.cr = cr_raw[7:0];
    end
  end

endmodule

### hw/rtl/rgb_to_yuv420_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter: RGB pixel stream to Y plus 2x2 averaged Cb/Cr
// Raster-order RGB in, one luma word per pixel out, with a chroma pair on
// the pixel that completes each subsampled block.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and returns one word per pixel,
// sustained at one per clock while out_tready stays high. The accept edge
// registers the pixel into the stage 1 registers and reads the line store at
// its column; the color math and the chroma averaging then go from stage 1
// into the output register, which holds the result word until it is taken.
// Even rows write their chroma to a MAX_WIDTH deep line store (one synchronous
// RAM holding Cb and Cr side by side); odd rows read it back, and a write
// followed at once by a read of the same column (one pixel wide frames) is
// forwarded. A chroma pair comes with out_tuser high at each odd column of an
// odd row, as a 2x1 average at a lone last column, and as row pairs on a
// final even row of an odd height frame. out_tlast marks the last pixel of a
// frame. frame_width and frame_height are written through the cfg port; the
// user must write them only while the block is idle, as the block itself does
// not enforce this. Zero counts as one and widths above MAX_WIDTH saturate.
module rgb_to_yuv420_converter (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel input, tdata: red[7:0], green[15:8], blue[23:16]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,
  // result output, tdata: luma[7:0], blue_diff[15:8], red_diff[23:16]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,
  // tuser: chroma_valid[0]
  output logic                               out_tuser,
  output logic                               out_tlast,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [r2y420_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [r2y420_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = r2y420_pkg::COL_W;

  // configuration registers
  logic [r2y420_pkg::FW_W-1:0] frame_width_r;
  logic [r2y420_pkg::FH_W-1:0] frame_height_r;

  // position counters
  logic [CW-1:0]  col_idx_r;
  logic [15:0]    row_idx_r;

  // stage 1 registers
  logic           s1_valid_r;
  logic [23:0]    s1_rgb_r;
  logic [CW-1:0]  s1_col_r;
  logic           s1_odd_row_r;
  logic           s1_odd_col_r;
  logic           s1_last_col_r;
  logic           s1_last_row_r;

  // line store, forwarding and left column sums
  logic [15:0]    line_mem [r2y420_pkg::MAX_WIDTH];
  logic [15:0]    mem_rd_r;
  logic           fwd_r;
  logic [15:0]    fwd_data_r;
  logic [8:0]     left_cb_r;
  logic [8:0]     left_cr_r;
  logic [8:0]     left_cb_nxt;
  logic [8:0]     left_cr_nxt;

  // output register
  logic           out_valid_r;
  logic [23:0]    out_tdata_r;
  logic           out_tuser_r;
  logic           out_tlast_r;

  // stage 0 combinational
  logic [CW:0]    w_eff;
  logic [15:0]    h_eff;
  logic [CW-1:0]  col_s;
  logic [15:0]    row_s;
  logic           last_col_s;
  logic           last_row_s;
  logic           en_out;
  logic           s1_go;
  logic           in_acc;

  // stage 1 combinational
  r2y420_pkg::ycc_t ycc;
  logic [15:0]    upper;
  logic [8:0]     scb;
  logic [8:0]     scr;
  logic [9:0]     sum4_cb;
  logic [9:0]     sum4_cr;
  logic [9:0]     sum2_cb;
  logic [9:0]     sum2_cr;
  logic           chroma_v;
  logic [7:0]     ocb;
  logic [7:0]     ocr;
  logic           mem_we;

  // pipeline flow
  assign en_out     = !out_valid_r || out_tready;
  assign s1_go      = s1_valid_r && en_out;
  assign in_tready  = !s1_valid_r || en_out;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= r2y420_pkg::RST_FRAME_WIDTH;
      frame_height_r <= r2y420_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      if (cfg_index == r2y420_pkg::REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_data[r2y420_pkg::FW_W-1:0];
      end
      if (cfg_index == r2y420_pkg::REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_data[r2y420_pkg::FH_W-1:0];
      end
    end
  end

  // effective frame size
  always_comb begin
    priority if (frame_width_r == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(frame_width_r) > 32'(r2y420_pkg::MAX_WIDTH)) begin
      w_eff = (CW+1)'(r2y420_pkg::MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width_r);
    end
    h_eff = (frame_height_r == '0) ? 16'd1 : frame_height_r;
  end

  // current position, held at the last column or row if the frame shrank
  assign col_s      = ((CW+1)'(col_idx_r) < w_eff) ? col_idx_r : CW'(w_eff - (CW+1)'(1));
  assign row_s      = (row_idx_r < h_eff) ? row_idx_r : (h_eff - 16'd1);
  assign last_col_s = (((CW+1)'(col_s) + (CW+1)'(1)) == w_eff);
  assign last_row_s = (row_s == (h_eff - 16'd1));

  // position counters advance on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_idx_r <= '0;
      row_idx_r <= '0;
    end else if (in_acc) begin
      if (last_col_s) begin
        col_idx_r <= '0;
        row_idx_r <= last_row_s ? 16'd0 : (row_s + 16'd1);
      end else begin
        col_idx_r <= col_s + CW'(1);
        row_idx_r <= row_s;
      end
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // stage 1 payload and forward capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_acc) begin
      fwd_r <= s1_go && !s1_odd_row_r && (s1_col_r == col_s);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rgb_r      <= in_tdata;
      s1_col_r      <= col_s;
      s1_odd_row_r  <= row_s[0];
      s1_odd_col_r  <= col_s[0];
      s1_last_col_r <= last_col_s;
      s1_last_row_r <= last_row_s;
      fwd_data_r    <= {ycc.cr, ycc.cb};
    end
  end

  // line store: read at accept, write when an even row word leaves stage 1
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_col_r] <= {ycc.cr, ycc.cb};
    end
    if (in_acc) begin
      mem_rd_r <= line_mem[col_s];
    end
  end

  // color math
  r2y420_csc u_csc (
    .red   (s1_rgb_r[7:0]),
    .green (s1_rgb_r[15:8]),
    .blue  (s1_rgb_r[23:16]),
    .ycc   (ycc)
  );

  // chroma sums against the upper row and the left column
  assign upper   = fwd_r ? fwd_data_r : mem_rd_r;
  assign scb     = {1'b0, upper[7:0]}  + {1'b0, ycc.cb};
  assign scr     = {1'b0, upper[15:8]} + {1'b0, ycc.cr};
  assign sum4_cb = {1'b0, left_cb_r} + {1'b0, scb};
  assign sum4_cr = {1'b0, left_cr_r} + {1'b0, scr};
  assign sum2_cb = {1'b0, left_cb_r} + 10'(ycc.cb);
  assign sum2_cr = {1'b0, left_cr_r} + 10'(ycc.cr);

  // chroma block decisions
  always_comb begin
    chroma_v    = 1'b0;
    ocb         = 8'h00;
    ocr         = 8'h00;
    left_cb_nxt = left_cb_r;
    left_cr_nxt = left_cr_r;
    mem_we      = 1'b0;
    if (s1_odd_row_r) begin
      if (s1_odd_col_r) begin
        chroma_v = 1'b1;
        ocb      = sum4_cb[9:2];
        ocr      = sum4_cr[9:2];
      end else if (s1_last_col_r) begin
        chroma_v = 1'b1;
        ocb      = scb[8:1];
        ocr      = scr[8:1];
      end else begin
        left_cb_nxt = scb;
        left_cr_nxt = scr;
      end
    end else begin
      mem_we = s1_go;
      if (s1_last_row_r) begin
        if (s1_odd_col_r) begin
          chroma_v = 1'b1;
          ocb      = sum2_cb[8:1];
          ocr      = sum2_cr[8:1];
        end else if (s1_last_col_r) begin
          chroma_v = 1'b1;
          ocb      = ycc.cb;
          ocr      = ycc.cr;
        end else begin
          left_cb_nxt = {1'b0, ycc.cb};
          left_cr_nxt = {1'b0, ycc.cr};
        end
      end
    end
  end

  // left column sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cb_r <= '0;
      left_cr_r <= '0;
    end else if (s1_go) begin
      left_cb_r <= left_cb_nxt;
      left_cr_r <= left_cr_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_tdata_r <= {ocr, ocb, ycc.luma};
      out_tuser_r <= chroma_v;
      out_tlast_r <= s1_last_col_r && s1_last_row_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rgb_to_yuv420_converter
// Streams RGB pixel words through the converter under several frame sizes
// and backpressure mixes. Each accepted pixel is run through a local
// BT.601 / 4:2:0 model, and every output word is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // color math coefficients
  localparam int LUMA_R  = 66;
  localparam int LUMA_G  = 129;
  localparam int LUMA_B  = 25;
  localparam int CB_MR   = 38;
  localparam int CB_MG   = 74;
  localparam int CB_PB   = 112;
  localparam int CR_PR   = 112;
  localparam int CR_MG   = 94;
  localparam int CR_MB   = 18;
  localparam int RND     = 128;
  localparam int LUMA_OF = 16;
  localparam int CHR_OF  = 128;
  localparam int LINE_MAX = 2048;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       fend;
  } yuv_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [23:0]                       in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [23:0]                       out_tdata;
  logic                              out_tuser;
  logic                              out_tlast;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [r2y420_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [r2y420_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // pixels waiting to be sent and output words still owed by the block
  logic [23:0] rgb_backlog[$];
  yuv_word_t   pending_yuv[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;

  // local copy of the converter state
  logic [11:0] shadow_width;
  logic [15:0] shadow_height;
  logic [7:0]  upper_cb[LINE_MAX];
  logic [7:0]  upper_cr[LINE_MAX];
  int          left_cb_sum;
  int          left_cr_sum;
  int          col_pos;
  int          row_pos;

  rgb_to_yuv420_converter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int sat_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // convert one pixel and advance the raster position
  function automatic yuv_word_t convert_pixel(input logic [23:0] px);
    int r, g, b, w, h, col, row, y, cb, cr, sum_cb, sum_cr;
    bit last_col, last_row;
    yuv_word_t res;
    r = px[7:0];
    g = px[15:8];
    b = px[23:16];
    w = shadow_width;
    h = shadow_height;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    if (h == 0) h = 1;
    col = (col_pos < w) ? col_pos : w - 1;
    row = (row_pos < h) ? row_pos : h - 1;
    last_col = (col + 1 == w);
    last_row = (row + 1 == h);
    y  = sat_byte(((LUMA_R * r + LUMA_G * g + LUMA_B * b + RND) >>> 8) + LUMA_OF);
    cb = sat_byte(((CB_PB * b + RND - CB_MR * r - CB_MG * g) >>> 8) + CHR_OF);
    cr = sat_byte(((CR_PR * r + RND - CR_MG * g - CR_MB * b) >>> 8) + CHR_OF);
    res = '0;
    res.luma = y[7:0];
    if (row[0]) begin
      // odd row: combine with the line above
      sum_cb = int'(upper_cb[col]) + cb;
      sum_cr = int'(upper_cr[col]) + cr;
      if (col[0]) begin
        res.chroma = 1'b1;
        res.cb = 8'((left_cb_sum + sum_cb) / 4);
        res.cr = 8'((left_cr_sum + sum_cr) / 4);
      end else if (last_col) begin
        res.chroma = 1'b1;
        res.cb = 8'(sum_cb / 2);
        res.cr = 8'(sum_cr / 2);
      end else begin
        left_cb_sum = sum_cb & 'h1FF;
        left_cr_sum = sum_cr & 'h1FF;
      end
    end else begin
      // even row: fill the line store, a final even row pairs horizontally
      upper_cb[col] = cb[7:0];
      upper_cr[col] = cr[7:0];
      if (last_row) begin
        if (col[0]) begin
          res.chroma = 1'b1;
          res.cb = 8'((left_cb_sum + cb) / 2);
          res.cr = 8'((left_cr_sum + cr) / 2);
        end else if (last_col) begin
          res.chroma = 1'b1;
          res.cb = cb[7:0];
          res.cr = cr[7:0];
        end else begin
          left_cb_sum = cb;
          left_cr_sum = cr;
        end
      end
    end
    if (last_col) begin
      col_pos = 0;
      if (last_row) begin
        res.fend = 1'b1;
        row_pos = 0;
      end else begin
        row_pos = (row + 1) & 'hFFFF;
      end
    end else begin
      col_pos = (col + 1) & 'h7FF;
      row_pos = row;
    end
    return res;
  endfunction

  // pixel driver, also tracks register writes for the local model
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      shadow_width = r2y420_pkg::RST_FRAME_WIDTH;
      shadow_height = r2y420_pkg::RST_FRAME_HEIGHT;
      left_cb_sum = 0;
      left_cr_sum = 0;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < LINE_MAX; i++) begin
        upper_cb[i] = '0;
        upper_cr[i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          r2y420_pkg::REG_FRAME_WIDTH: begin
            shadow_width = cfg_data[11:0];
          end
          r2y420_pkg::REG_FRAME_HEIGHT: begin
            shadow_height = cfg_data[15:0];
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) pending_yuv.push_back(convert_pixel(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (rgb_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= rgb_backlog.pop_front();
        end else begin
          in_tvalid <= 1'b0;
          in_tdata <= 24'($urandom);
        end
      end
    end
  end

  // output monitor and ready generator
  always @(posedge clk) begin : monitor
    yuv_word_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got.luma = out_tdata[7:0];
        got.chroma = out_tuser;
        got.cb = out_tdata[15:8];
        got.cr = out_tdata[23:16];
        got.fend = out_tlast;
        if (pending_yuv.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected word luma=%0d cv=%0b cb=%0d cr=%0d last=%0b",
                     $realtime, got.luma, got.chroma, got.cb, got.cr, got.fend);
          err_count++;
        end else begin
          want = pending_yuv.pop_front();
          if (got !== want) begin
            if (err_count < 10)
              $display("%0t: mismatch luma %0d/%0d cv %0b/%0b cb %0d/%0d cr %0d/%0d last %0b/%0b",
                       $realtime, want.luma, got.luma, want.chroma, got.chroma,
                       want.cb, got.cb, want.cr, got.cr, want.fend, got.fend);
            err_count++;
          end
        end
      end
    end
  end

  // one register write through the cfg channel
  task automatic cfg_write(input logic [r2y420_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until every pixel is sent and every word has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (rgb_backlog.size() != 0 || in_tvalid || pending_yuv.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_random(input int count);
    repeat (count) rgb_backlog.push_back({pick_byte(), pick_byte(), pick_byte()});
  endtask

  // reprogram the frame size, then queue whole frames; returns pixel count
  task automatic load_frames(input logic [15:0] wdata, input logic [15:0] hdata,
                             input int frames, output int pixels);
    int we, he;
    we = wdata[11:0];
    he = hdata;
    if (we == 0) we = 1;
    if (we > LINE_MAX) we = LINE_MAX;
    if (he == 0) he = 1;
    wait_idle();
    cfg_write(r2y420_pkg::REG_FRAME_WIDTH, wdata);
    cfg_write(r2y420_pkg::REG_FRAME_HEIGHT, hdata);
    pixels = we * he * frames;
    push_random(pixels);
  endtask

  // stimulus sequence
  initial begin : stimulus
    int n, sent, w, h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 5x3 frame: 2x2 blocks, lone last column, final row pairs, lone corner
    wait_idle();
    cfg_write(r2y420_pkg::REG_FRAME_WIDTH, 16'd5);
    cfg_write(r2y420_pkg::REG_FRAME_HEIGHT, 16'd3);
    rgb_backlog.push_back(24'h000000);
    rgb_backlog.push_back(24'hFFFFFF);
    rgb_backlog.push_back(24'h0000FF);
    rgb_backlog.push_back(24'h00FF00);
    rgb_backlog.push_back(24'hFF0000);
    rgb_backlog.push_back(24'hFFFF00);
    rgb_backlog.push_back(24'hFF00FF);
    rgb_backlog.push_back(24'h00FFFF);
    rgb_backlog.push_back(24'h808080);
    rgb_backlog.push_back(24'h7F7F7F);
    push_random(5);

    // zero sizes act as one pixel frames, upper width bits ignored
    wait_idle();
    cfg_write(r2y420_pkg::REG_FRAME_WIDTH, 16'hF000);
    cfg_write(r2y420_pkg::REG_FRAME_HEIGHT, 16'd0);
    rgb_backlog.push_back(24'hFFFFFF);
    rgb_backlog.push_back(24'h000000);

    // plain 2x2 frame
    load_frames(16'd2, 16'd2, 1, n);

    // tallest frame, cut short by shrinking the height mid-frame
    load_frames(16'd3, 16'hFFFF, 0, n);
    push_random(7);
    wait_idle();
    cfg_write(r2y420_pkg::REG_FRAME_HEIGHT, 16'd2);
    push_random(2);

    // column past a shrunken width
    load_frames(16'd6, 16'd2, 0, n);
    push_random(8);
    wait_idle();
    cfg_write(r2y420_pkg::REG_FRAME_WIDTH, 16'd2);
    push_random(1);

    // widest setting: start of a long row, closed by shrinking to one column
    load_frames(16'h0FFF, 16'd1, 0, n);
    push_random(16);
    wait_idle();
    cfg_write(r2y420_pkg::REG_FRAME_WIDTH, 16'd1);
    push_random(1);
    load_frames(16'd1, 16'd1, 2, n);

    // random frames under each backpressure mix
    for (int mode = 0; mode < 4; mode++) begin
      wait_idle();
      send_idle_pct = (mode == 1) ? 86 : (mode == 3) ? 19 : 0;
      recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 19 : 0;
      sent = 0;
      while (sent < 80) begin
        w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        load_frames({4'($urandom), 12'(w)}, 16'(h), $urandom_range(1, 2), n);
        sent += n;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_yuv.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
